// ----- rtl/mpfr_pkg.sv -----
`timescale 1ns / 1ps

package mpfr_pkg;

  // Page geometry limits and derived store sizes.
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int PAGE_ROWS   = (MAX_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = MAX_WIDTH * PAGE_ROWS;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int ROW_W       = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;

  // Effective geometry is held in nine bits, enough for any eight-bit width
  // register clamped to the largest supported page.
  localparam int GEO_W = 9;

  // Register indexes on the configuration port.
  localparam logic REG_PAGE_WIDTH  = 1'b0;
  localparam logic REG_PAGE_HEIGHT = 1'b1;

  // Reset values of the geometry registers.
  localparam logic [7:0] PAGE_WIDTH_RST  = 8'd128;
  localparam logic [6:0] PAGE_HEIGHT_RST = 7'd64;

  // Fill patterns.
  localparam logic [7:0] BYTE_CLEAR = 8'h00;
  localparam logic [7:0] BYTE_SET   = 8'hff;
  localparam logic [7:0] BIT_ONE    = 8'h01;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_COMBINE = 2'd2,
    OP_FILL    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROP_COPY = 2'd0,
    ROP_OR   = 2'd1,
    ROP_AND  = 2'd2,
    ROP_XOR  = 2'd3
  } rop_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               pixel_value;
    rop_t               raster_op;
  } in_item_t;

  typedef struct packed {
    logic read_pixel;
    logic in_range;
  } out_item_t;

  // Effective page geometry after clamping and rounding.
  typedef struct packed {
    logic [GEO_W-1:0] width;
    logic [GEO_W-1:0] height;
  } geom_t;

  // Decoded word waiting for its store read.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    op_t               opcode;
    logic              src;
    rop_t              rop;
    logic              in_range;
  } dec_item_t;

endpackage

// ----- rtl/mono_page_framebuffer_rop_core.sv -----
`timescale 1ns / 1ps

// Channel  Ports                                   Word
// -------  --------------------------------------  --------------------------------
// in       in_valid, in_ready, in_data             opcode, pos_x, pos_y, pixel, rop
// out      out_valid, out_ready, out_data          read_pixel, in_range
// config   psel, penable, pwrite, paddr, pwdata,   page_width at 0, page_height at 4
//          prdata, pready
//
// One word is accepted per cycle unless a stalled result holds the pipeline. Each word
// passes the decode, modify and result registers before its out_valid rises.
// The rate is set by the store's read-modify-write, with a write to the same byte
// in the previous word forwarded around the registered memory read.
// Reset is synchronous and active low; it clears the stage valids and sets the
// geometry to 128 by 64. The pixel store is not cleared; fill words clear it.
// A stalled result holds the pipeline; empty stages still accept new words.
module mono_page_framebuffer_rop_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mpfr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mpfr_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  mpfr_pkg::geom_t     geom;
  logic                dec_valid;
  logic                dec_ready;
  mpfr_pkg::dec_item_t dec_data;

  assign pready = 1'b1;

  // Geometry registers.
  mpfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .geom    (geom)
  );

  // Clip and address decode.
  mpfr_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .geom       (geom),
    .next_ready (dec_ready),
    .dec_valid  (dec_valid),
    .dec_data   (dec_data)
  );

  // Store read-modify-write and result register.
  mpfr_rmw u_rmw (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_data  (dec_data),
    .dec_ready (dec_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/mpfr_cfg.sv -----
`timescale 1ns / 1ps

module mpfr_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output mpfr_pkg::geom_t       geom
);

  logic [7:0] width_r;
  logic [7:0] width_nxt;
  logic [6:0] height_r;
  logic [6:0] height_nxt;
  logic       wr_en;
  logic       reg_idx;
  logic [8:0] width_ext;
  logic [7:0] height_sum;
  logic [8:0] height_up;

  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      case (reg_idx)
        mpfr_pkg::REG_PAGE_WIDTH:  width_nxt  = pwdata[7:0];
        mpfr_pkg::REG_PAGE_HEIGHT: height_nxt = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mpfr_pkg::PAGE_WIDTH_RST;
      height_r <= mpfr_pkg::PAGE_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Read back the raw register values.
  always_comb begin
    case (reg_idx)
      mpfr_pkg::REG_PAGE_WIDTH:  prdata = {24'd0, width_r};
      mpfr_pkg::REG_PAGE_HEIGHT: prdata = {25'd0, height_r};
      default:                   prdata = 32'd0;
    endcase
  end

  // Clamp the width, and round the height up to whole pages of eight rows and clamp it.
  assign width_ext  = {1'b0, width_r};
  assign height_sum = {1'b0, height_r} + 8'd7;
  assign height_up  = {1'b0, height_sum[7:3], 3'b000};

  always_comb begin
    if (width_ext > 9'(mpfr_pkg::MAX_WIDTH)) begin
      geom.width = 9'(mpfr_pkg::MAX_WIDTH);
    end else begin
      geom.width = width_ext;
    end
    if (height_up > 9'(mpfr_pkg::MAX_HEIGHT)) begin
      geom.height = 9'(mpfr_pkg::MAX_HEIGHT);
    end else begin
      geom.height = height_up;
    end
  end

endmodule

// ----- rtl/mpfr_decode.sv -----
`timescale 1ns / 1ps

module mpfr_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mpfr_pkg::in_item_t    in_data,
  input  mpfr_pkg::geom_t       geom,
  input  logic                  next_ready,
  output logic                  dec_valid,
  output mpfr_pkg::dec_item_t   dec_data
);

  logic                        dec_valid_r;
  logic                        dec_valid_nxt;
  mpfr_pkg::dec_item_t         dec_r;
  mpfr_pkg::dec_item_t         dec_nxt;
  logic                        x_ok;
  logic                        y_ok;
  logic [mpfr_pkg::ROW_W-1:0]  row;
  logic [mpfr_pkg::ADDR_W-1:0] row_base;

  // The stage takes a word when it is empty or its word moves on.
  assign in_ready = !dec_valid_r || next_ready;

  // Clip against the effective page.
  assign x_ok = !in_data.pos_x[15] && (16'(in_data.pos_x) < 16'(geom.width));
  assign y_ok = !in_data.pos_y[15] && (16'(in_data.pos_y) < 16'(geom.height));

  // Byte address is page row times width plus column.
  assign row      = in_data.pos_y[mpfr_pkg::ROW_W+2:3];
  assign row_base = mpfr_pkg::ADDR_W'(mpfr_pkg::ADDR_W'(row) *
                                      mpfr_pkg::ADDR_W'(geom.width));

  always_comb begin
    dec_nxt.addr     = row_base + in_data.pos_x[mpfr_pkg::ADDR_W-1:0];
    dec_nxt.bit_sel  = in_data.pos_y[2:0];
    dec_nxt.opcode   = in_data.opcode;
    dec_nxt.src      = in_data.pixel_value;
    dec_nxt.rop      = in_data.raster_op;
    dec_nxt.in_range = x_ok && y_ok;
  end

  assign dec_valid_nxt = in_ready ? in_valid : dec_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else begin
      dec_valid_r <= dec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_valid = dec_valid_r;
  assign dec_data  = dec_r;

endmodule

// ----- rtl/mpfr_rmw.sv -----
`timescale 1ns / 1ps

module mpfr_rmw (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  dec_valid,
  input  mpfr_pkg::dec_item_t   dec_data,
  output logic                  dec_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mpfr_pkg::out_item_t   out_data
);

  logic [7:0]          mem [mpfr_pkg::STORE_BYTES];
  logic [7:0]          mem_q_r;
  logic                fwd_hit_r;
  logic                fwd_hit_nxt;
  logic [7:0]          fwd_byte_r;
  logic                mod_valid_r;
  logic                mod_valid_nxt;
  mpfr_pkg::dec_item_t mod_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  mpfr_pkg::out_item_t out_r;
  mpfr_pkg::out_item_t out_nxt;
  logic                out_adv;
  logic                mod_adv;
  logic [7:0]          old_byte;
  logic                old_pix;
  logic                new_pix;
  logic [7:0]          bit_mask;
  logic [7:0]          new_byte;
  logic                wr_en;

  // Stage enables: each stage moves when the one after it has room.
  assign out_adv   = !out_valid_r || out_ready;
  assign mod_adv   = !mod_valid_r || out_adv;
  assign dec_ready = mod_adv;

  // Stored byte, with the byte written in the same cycle as the read forwarded.
  assign old_byte = fwd_hit_r ? fwd_byte_r : mem_q_r;
  assign old_pix  = old_byte[mod_r.bit_sel];
  assign bit_mask = mpfr_pkg::BIT_ONE << mod_r.bit_sel;

  // Raster operation on the single pixel.
  always_comb begin
    new_pix = mod_r.src;
    if (mod_r.opcode == mpfr_pkg::OP_COMBINE) begin
      case (mod_r.rop)
        mpfr_pkg::ROP_COPY: new_pix = mod_r.src;
        mpfr_pkg::ROP_OR:   new_pix = mod_r.src | old_pix;
        mpfr_pkg::ROP_AND:  new_pix = mod_r.src & old_pix;
        mpfr_pkg::ROP_XOR:  new_pix = mod_r.src ^ old_pix;
        default:            new_pix = mod_r.src;
      endcase
    end
  end

  // New byte contents and write enable.
  always_comb begin
    case (mod_r.opcode)
      mpfr_pkg::OP_FILL: begin
        new_byte = mod_r.src ? mpfr_pkg::BYTE_SET : mpfr_pkg::BYTE_CLEAR;
      end
      mpfr_pkg::OP_WRITE, mpfr_pkg::OP_COMBINE: begin
        new_byte = new_pix ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
      end
      default: begin
        new_byte = old_byte;
      end
    endcase
  end

  assign wr_en = mod_valid_r && out_adv && mod_r.in_range &&
                 (mod_r.opcode != mpfr_pkg::OP_READ);

  assign fwd_hit_nxt = wr_en && dec_valid && (dec_data.addr == mod_r.addr);

  // Pixel store: one write and one registered read per cycle, both held while the modify stage stalls.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mod_r.addr] <= new_byte;
    end
    if (mod_adv) begin
      mem_q_r <= mem[dec_data.addr];
    end
  end

  // Forwarding registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (mod_adv) begin
      fwd_hit_r <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_adv) begin
      fwd_byte_r <= new_byte;
    end
  end

  // Modify stage.
  assign mod_valid_nxt = mod_adv ? dec_valid : mod_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_valid_r <= 1'b0;
    end else begin
      mod_valid_r <= mod_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_adv) begin
      mod_r <= dec_data;
    end
  end

  // Result register.
  always_comb begin
    out_nxt.read_pixel = mod_r.in_range & old_pix;
    out_nxt.in_range   = mod_r.in_range;
  end

  assign out_valid_nxt = out_adv ? mod_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A clipped word never touches the store.
  a_no_clip_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> mod_r.in_range)
    else $error("store written for a word outside the page");

  // Forwarding only applies to a word that sits in the modify stage.
  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> mod_valid_r)
    else $error("forwarding flag set with empty modify stage");

  // A word held in the modify stage is not dropped while the result stalls.
  a_mod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mod_valid_r && !out_adv) |=> mod_valid_r)
    else $error("modify stage lost a word during a stall");

  // A result outside the page always reads as zero.
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.in_range) |-> !out_r.read_pixel)
    else $error("clipped result carries a pixel");

endmodule
